### rtl/gfip_pkg.sv
// Shared types, constants and helper functions of the masked GF(2^8) inner product block.
package gfip_pkg;

  localparam int MAX_SHARES = 4;
  localparam int RAND_BYTES = 6;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  typedef logic [7:0] byte_t;

  // Register indexes, taken from paddr[2].
  typedef enum logic {
    REG_REDUCTION_POLY = 1'b0
  } reg_idx_t;

  localparam byte_t POLY_RESET = 8'd27;

  // What one lane hands to the merging stage.
  typedef struct packed {
    byte_t prod;  // XOR of a[lane] * b[j] over all shares j
    byte_t mask;  // XOR of the resharing bytes of every pair that holds this lane
  } lane_res_t;

  // Position of the random byte of share pair (i, j), i < j, in loop order.
  function automatic int pair_index(input int n, input int i, input int j);
    return ((i * (2 * n - i - 1)) >> 1) + (j - i - 1);
  endfunction

endpackage

### rtl/gfip_gf_mul.sv
// Combinational shift-and-reduce GF(2^8) multiplier with a programmable polynomial.
module gfip_gf_mul (
  input  gfip_pkg::byte_t a,
  input  gfip_pkg::byte_t b,
  input  gfip_pkg::byte_t poly,
  output gfip_pkg::byte_t p
);
  import gfip_pkg::*;

  always_comb begin
    byte_t acc;
    byte_t sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ sh;
      end
      if (sh[7]) begin
        sh = {sh[6:0], 1'b0} ^ poly;
      end else begin
        sh = {sh[6:0], 1'b0};
      end
    end
    p = acc;
  end

endmodule

### rtl/gfip_lane.sv
// One share lane: the products of its a share with every b share and its resharing mask.
module gfip_lane #(
  parameter int SHARES = 4,
  parameter int LANE   = 0
) (
  input  gfip_pkg::byte_t                       a_share,
  input  logic [8*SHARES-1:0]                   b_vec,
  input  gfip_pkg::byte_t                       poly,
  input  logic [8*gfip_pkg::RAND_BYTES-1:0]     rnd,
  output gfip_pkg::lane_res_t                   res
);
  import gfip_pkg::*;

  byte_t prods [SHARES];
  byte_t masks [SHARES];

  for (genvar j = 0; j < SHARES; j++) begin : g_col
    gfip_gf_mul u_mul (
      .a    (a_share),
      .b    (b_vec[8*j +: 8]),
      .poly (poly),
      .p    (prods[j])
    );

    if (j == LANE) begin : g_diag
      assign masks[j] = '0;
    end else begin : g_pair
      localparam int Lo  = (j < LANE) ? j : LANE;
      localparam int Hi  = (j < LANE) ? LANE : j;
      localparam int Idx = pair_index(SHARES, Lo, Hi);
      assign masks[j] = rnd[8*Idx +: 8];
    end
  end

  always_comb begin
    res.prod = '0;
    res.mask = '0;
    for (int j = 0; j < SHARES; j++) begin
      res.prod = res.prod ^ prods[j];
      res.mask = res.mask ^ masks[j];
    end
  end

endmodule

### rtl/masked_gf256_inner_product.sv
// A word marked last shows its result on z_shares in the cycle after it is accepted.
// Throughput: one input word per cycle; every lane multiplies its share by all b shares at once.
// A word not marked last is taken even while a result waits; a last word waits for the
// output register to free up. Synchronous reset clears the row accumulators, the output
// valid flag and sets reduction_poly to 27.
module masked_gf256_inner_product #(
  parameter int SHARES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gfip_pkg::ADDR_W-1:0]   paddr,
  input  logic [gfip_pkg::DATA_W-1:0]   pwdata,
  output logic [gfip_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   a_shares,
  input  logic [31:0]                   b_shares,
  input  logic                          is_last,
  input  logic [47:0]                   random_bytes,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   z_shares
);
  import gfip_pkg::*;

  // Share counts above the packed field width fall back to the full width.
  localparam int N = (SHARES > MAX_SHARES) ? MAX_SHARES : SHARES;

  // ---------------------------------------------------------------------------
  // Configuration register. Only one register exists; the low address bits
  // below paddr[2] are ignored.
  // ---------------------------------------------------------------------------
  byte_t poly;
  logic  cfg_sel;

  assign cfg_sel = (reg_idx_t'(paddr[2]) == REG_REDUCTION_POLY);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? {{(DATA_W-8){1'b0}}, poly} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= POLY_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      poly <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Lanes. Lane i forms every product a[i]*b[j]. Only the XOR of a row reaches
  // the output, so each lane keeps one row accumulator that stands for the
  // diagonal sum and all cross sums of that row. The resharing bytes enter a
  // row once for each pair that contains the row's share.
  // ---------------------------------------------------------------------------
  lane_res_t lane_res [N];

  for (genvar i = 0; i < N; i++) begin : g_lane
    gfip_lane #(
      .SHARES (N),
      .LANE   (i)
    ) u_lane (
      .a_share (a_shares[8*i +: 8]),
      .b_vec   (b_shares[8*N-1:0]),
      .poly    (poly),
      .rnd     (random_bytes),
      .res     (lane_res[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Handshake. A word that is not last only touches the accumulators, so it
  // can pass while a finished result waits in the output register.
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_fire;

  assign in_ready = !out_valid || out_ready || !is_last;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // ---------------------------------------------------------------------------
  // Merging stage: row accumulators and the output register.
  // ---------------------------------------------------------------------------
  byte_t       acc [N];
  logic [31:0] z_next;
  logic        acc_any;

  always_comb begin
    z_next = '0;
    for (int i = 0; i < N; i++) begin
      z_next[8*i +: 8] = acc[i] ^ lane_res[i].prod ^ lane_res[i].mask;
    end
  end

  always_comb begin
    acc_any = 1'b0;
    for (int i = 0; i < N; i++) begin
      acc_any = acc_any | (|acc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        acc[i] <= '0;
      end
    end else if (in_fire) begin
      for (int i = 0; i < N; i++) begin
        if (is_last) begin
          acc[i] <= '0;
        end else begin
          acc[i] <= acc[i] ^ lane_res[i].prod;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && is_last) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_last) begin
      z_shares <= z_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && is_last))
    else $error("result appeared without a last word");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_last) |=> !acc_any)
    else $error("accumulators not cleared after a last word");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((z_shares >> (8 * N)) == 32'd0))
    else $error("unused result share bytes are not zero");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && is_last))
    else $error("input stalled without a waiting result");

endmodule

### tb/sv/masked_gf256_inner_product_tb.sv
// Self-checking testbench of the masked GF(2^8) inner product block.
module masked_gf256_inner_product_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gfip_pkg::*;

  localparam int SHARES      = 4;
  // Cycles with no word moving on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  // Length of the long receiver hold-off that forces the block to back up.
  localparam int HOLD_CYCLES = 400;
  // Settling time after the last expected result.
  localparam int SETTLE      = 4;

  // One input word as the sender keeps it until it is handed over.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        last;
    logic [47:0] rnd;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [31:0]         a_shares     = '0;
  logic [31:0]         b_shares     = '0;
  logic                is_last      = 1'b0;
  logic [47:0]         random_bytes = '0;

  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [31:0]         z_shares;

  masked_gf256_inner_product #(
    .SHARES(SHARES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .a_shares    (a_shares),
    .b_shares    (b_shares),
    .is_last     (is_last),
    .random_bytes(random_bytes),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .z_shares    (z_shares)
  );

  always #5 clk = ~clk;

  // Words waiting to be offered, and the z values the predictor says must come out.
  word_t       words_to_send[$];
  logic [31:0] z_due[$];
  int          words_queued = 0;
  int          words_taken  = 0;
  int          fail_count   = 0;

  // Idle rates in percent for both sides, and the toggle that starts a long hold-off.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req      = 1'b0;

  // Predictor state: the running cross and diagonal sums of the current vector and the
  // reduction polynomial the block is believed to hold.
  byte_t cross_acc[MAX_SHARES][MAX_SHARES];
  byte_t diag_acc[MAX_SHARES];
  byte_t poly_now = POLY_RESET;

  task automatic report_failure(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    fail_count++;
  endtask

  // Plain shift-and-reduce multiply. The polynomial may be zero or reducible; the
  // block does the same steps with whatever is written, so nothing special happens here.
  function automatic byte_t gf_mul(input byte_t x, input byte_t y, input byte_t p);
    byte_t acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (y[0]) acc ^= x;
      y = y >> 1;
      x = x[7] ? byte_t'((x << 1) ^ p) : byte_t'(x << 1);
    end
    return acc;
  endfunction

  // Folds one accepted word into the running sums. On the last word of a vector the
  // symmetric cross pairs get their resharing byte, the z shares are formed and queued,
  // and the sums start over.
  task automatic absorb_word(input word_t w);
    int          n;
    int          r;
    byte_t       rb;
    byte_t       s;
    logic [31:0] z;
    n = (SHARES > MAX_SHARES) ? MAX_SHARES : SHARES;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (i == j) begin
          diag_acc[i] ^= gf_mul(w.a[8*i +: 8], w.b[8*i +: 8], poly_now);
        end else begin
          cross_acc[i][j] ^= gf_mul(w.a[8*i +: 8], w.b[8*j +: 8], poly_now);
        end
      end
    end
    if (!w.last) return;
    // Random bytes are consumed in i < j loop order, starting from the low byte.
    r = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        rb = (r < RAND_BYTES) ? w.rnd[8*r +: 8] : 8'h00;
        r++;
        cross_acc[i][j] ^= rb;
        cross_acc[j][i] ^= rb;
      end
    end
    // Shares at or above the share count stay zero.
    z = '0;
    for (int i = 0; i < n; i++) begin
      s = diag_acc[i];
      for (int j = 0; j < n; j++) begin
        if (j != i) s ^= cross_acc[i][j];
      end
      z[8*i +: 8] = s;
    end
    z_due.push_back(z);
    foreach (cross_acc[i, j]) cross_acc[i][j] = '0;
    foreach (diag_acc[i]) diag_acc[i] = '0;
  endtask

  initial begin
    foreach (cross_acc[i, j]) cross_acc[i][j] = '0;
    foreach (diag_acc[i]) diag_acc[i] = '0;
  end

  // Sender. A word stays on the bus unchanged until it is taken; once taken it goes to
  // the predictor, and the next word is offered unless the sender decides to idle.
  always @(posedge clk) begin
    word_t taken;
    word_t next_word;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.a    = a_shares;
        taken.b    = b_shares;
        taken.last = is_last;
        taken.rnd  = random_bytes;
        absorb_word(taken);
        words_taken++;
      end
      if (in_valid && !in_ready) begin
        // Hold the current word.
      end else if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = words_to_send.pop_front();
        in_valid     <= 1'b1;
        a_shares     <= next_word.a;
        b_shares     <= next_word.b;
        is_last      <= next_word.last;
        random_bytes <= next_word.rnd;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Each word taken from the output is compared with the oldest expected z.
  // A toggle of hold_req starts a long hold-off that this process counts down itself.
  int   hold_left = 0;
  logic hold_seen = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_req;
    end else begin
      if (out_valid && out_ready) begin
        if (z_due.size() == 0) begin
          report_failure($sformatf("unexpected result z_shares=%08h", z_shares));
        end else if (z_shares !== z_due[0]) begin
          report_failure($sformatf("z_shares mismatch: got %08h, want %08h",
                                   z_shares, z_due[0]));
          void'(z_due.pop_front());
        end else begin
          void'(z_due.pop_front());
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any run of cycles with no word moving on either channel that grows past
  // the limit means the block has hung.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes the polynomial register through a setup and an access phase, then reads it
  // back. Only called while the block is idle, so the predictor can switch at once.
  task automatic poly_write(input byte_t value);
    logic [ADDR_W-1:0] addr;
    addr = ADDR_W'(REG_REDUCTION_POLY) << 2;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    poly_now = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) begin
      report_failure($sformatf("reduction_poly read back %02h, want %02h",
                               prdata[7:0], value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_word(input logic [31:0] a, input logic [31:0] b,
                           input logic last, input logic [47:0] rnd);
    word_t w;
    w.a    = a;
    w.b    = b;
    w.last = last;
    w.rnd  = rnd;
    words_to_send.push_back(w);
    words_queued++;
  endtask

  // Bytes lean toward the corners of the field: zero, all ones, the top bit that
  // triggers a reduction, and one, with plain random bytes in between.
  function automatic byte_t pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h01;
      default: return byte_t'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_shares();
    return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
  endfunction

  // Queues whole vectors, each closed by a last word, until the target count is met.
  // Most vectors are short so results come often; a few run long.
  task automatic fill_random(input int target, input int max_len);
    int count;
    int len;
    logic [47:0] rnd;
    count = 0;
    while (count < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, max_len);
      for (int k = 0; k < len; k++) begin
        rnd = 48'({$urandom, $urandom});
        if ($urandom_range(5) == 0) rnd = {pick_byte(), pick_byte(), pick_byte(),
                                           pick_byte(), pick_byte(), pick_byte()};
        push_word(pick_shares(), pick_shares(), k == len - 1, rnd);
      end
      count += len;
    end
  endtask

  // Waits until every queued word is taken and every expected z has come out, then
  // lets the block settle before anything else happens.
  task automatic wait_drained();
    while (words_taken != words_queued || z_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset polynomial: all-zero and all-one operands, the
    // resharing bytes at both extremes, products that need reduction, random bytes on
    // words that are not last (they must be ignored), and multi-word vectors.
    push_word(32'h0000_0000, 32'h0000_0000, 1'b1, 48'h0000_0000_0000);
    push_word(32'hffff_ffff, 32'hffff_ffff, 1'b1, 48'h0000_0000_0000);
    push_word(32'hffff_ffff, 32'hffff_ffff, 1'b1, 48'hffff_ffff_ffff);
    push_word(32'h8080_8080, 32'h0202_0202, 1'b1, 48'h0102_0408_1020);
    push_word(32'h0102_0408, 32'h0101_0101, 1'b1, 48'h0000_0000_0000);
    push_word(32'h0000_0000, 32'hffff_ffff, 1'b1, 48'h5555_5555_5555);
    push_word(32'h8040_2010, 32'h0804_0201, 1'b1, 48'haaaa_aaaa_aaaa);
    push_word(32'h5555_5555, 32'haaaa_aaaa, 1'b0, 48'hffff_ffff_ffff);
    push_word(32'haaaa_aaaa, 32'h5555_5555, 1'b0, 48'hffff_ffff_ffff);
    push_word(32'hffff_ffff, 32'h8080_8080, 1'b0, 48'h1234_5678_9abc);
    push_word(32'h0123_4567, 32'h89ab_cdef, 1'b1, 48'h0000_0000_0001);
    push_word(32'hdead_beef, 32'h0000_0000, 1'b0, 48'hffff_ffff_ffff);
    push_word(32'h0000_0000, 32'h0000_0000, 1'b0, 48'h0000_0000_0000);
    push_word(32'hfedc_ba98, 32'h7654_3210, 1'b1, 48'h8000_0000_0000);
    push_word(32'h0000_00ff, 32'hff00_0000, 1'b1, 48'h00ff_00ff_00ff);
    push_word(32'h8000_0001, 32'h8000_0001, 1'b1, 48'hff00_ff00_ff00);
    push_word(32'hffff_ffff, 32'hffff_ffff, 1'b0, 48'h0000_0000_0000);
    push_word(32'hffff_ffff, 32'hffff_ffff, 1'b1, 48'hffff_ffff_ffff);
    wait_drained();

    // All-ones polynomial; the sender idles often and the receiver idles more.
    poly_write(8'hff);
    send_idle_pct <= 38;
    recv_idle_pct <= 62;
    fill_random(480, 6);
    wait_drained();

    // Zero polynomial, so the top bit simply falls off; idle rates swapped.
    poly_write(8'h00);
    send_idle_pct <= 62;
    recv_idle_pct <= 38;
    fill_random(480, 6);
    wait_drained();

    // A common irreducible polynomial at full speed on both sides.
    poly_write(8'h1d);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    fill_random(480, 6);
    wait_drained();

    // Random polynomial with short vectors while the receiver holds off for a long
    // stretch, so the output register stays full and last words back up at the input.
    poly_write(byte_t'($urandom));
    hold_req <= ~hold_req;
    fill_random(480, 3);
    wait_drained();

    foreach (z_due[i]) report_failure($sformatf("result %08h never arrived", z_due[i]));
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gfip_pkg.sv
rtl/gfip_gf_mul.sv
rtl/gfip_lane.sv
rtl/masked_gf256_inner_product.sv
tb/sv/masked_gf256_inner_product_tb.sv
